// ===== src/ppdf_pkg.sv =====
// ----------------------------------------------------------------------------
// ppdf_pkg: shared types and widths for the point-to-plane distance block
// Coordinate, difference and wide datapath widths, the input and result
// words, and the request bundle for the shared adder/subtractor.
// ----------------------------------------------------------------------------
package ppdf_pkg;

   localparam int COORD_WIDTH = 24;
   localparam int DIFF_W      = COORD_WIDTH + 1;
   localparam int NORM_W      = 2 * COORD_WIDTH + 3;
   localparam int DOT_W       = 3 * COORD_WIDTH + 6;
   localparam int WIDE_W      = 6 * COORD_WIDTH + 16;
   localparam int CNT_W       = $clog2(DOT_W);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]      diff_type;
   typedef logic [WIDE_W-1:0]             wide_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
      coord_type first_x;
      coord_type first_y;
      coord_type first_z;
      coord_type second_x;
      coord_type second_y;
      coord_type second_z;
      coord_type third_x;
      coord_type third_y;
      coord_type third_z;
   } coords_type;

   typedef struct packed {
      logic [COORD_WIDTH-1:0] distance;
      coord_type              foot_x;
      coord_type              foot_y;
      coord_type              foot_z;
      logic                   degenerate;
   } result_type;

   typedef struct packed {
      wide_type x;
      wide_type y;
      logic     sub;
   } addsub_req_type;

endpackage

// ===== src/ppdf_addsub.sv =====
// ----------------------------------------------------------------------------
// ppdf_addsub: shared wide adder/subtractor
// Two's complement x + y or x - y over the full datapath width.
// ----------------------------------------------------------------------------
module ppdf_addsub import ppdf_pkg::*; (
   input  addsub_req_type req,
   output wide_type       sum
);

   assign sum = req.x + (req.y ^ {WIDE_W{req.sub}}) + WIDE_W'(req.sub);

endmodule

// ===== src/ppdf_engine.sv =====
// ----------------------------------------------------------------------------
// ppdf_engine: sequencer and datapath around the shared adder
// Shift-add multiplies for normal, dot product, norm, d squared and
// numerators, a bit-per-step square root for the distance and restoring
// divides for the rounded foot coordinates.
// ----------------------------------------------------------------------------
module ppdf_engine import ppdf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  coords_type     coords,
   input  logic           take,
   output logic           ready,
   output logic           done,
   output result_type     result,
   output addsub_req_type alu_req,
   input  wide_type       alu_sum
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SETUP  = 4'd1;
   localparam logic [3:0] S_MAC    = 4'd2;
   localparam logic [3:0] S_SQRT_T = 4'd3;
   localparam logic [3:0] S_SQRT_S = 4'd4;
   localparam logic [3:0] S_SQRT_A = 4'd5;
   localparam logic [3:0] S_ABS    = 4'd6;
   localparam logic [3:0] S_LIM    = 4'd7;
   localparam logic [3:0] S_DIV    = 4'd8;
   localparam logic [3:0] S_DONE   = 4'd9;

   localparam logic [4:0] OP_NX_A = 5'd0;
   localparam logic [4:0] OP_NX_B = 5'd1;
   localparam logic [4:0] OP_NY_A = 5'd2;
   localparam logic [4:0] OP_NY_B = 5'd3;
   localparam logic [4:0] OP_NZ_A = 5'd4;
   localparam logic [4:0] OP_NZ_B = 5'd5;
   localparam logic [4:0] OP_D_A  = 5'd6;
   localparam logic [4:0] OP_D_B  = 5'd7;
   localparam logic [4:0] OP_D_C  = 5'd8;
   localparam logic [4:0] OP_NN_A = 5'd9;
   localparam logic [4:0] OP_NN_B = 5'd10;
   localparam logic [4:0] OP_NN_C = 5'd11;
   localparam logic [4:0] OP_DSQ  = 5'd12;
   localparam logic [4:0] OP_FX_A = 5'd13;
   localparam logic [4:0] OP_FX_B = 5'd14;
   localparam logic [4:0] OP_FY_A = 5'd15;
   localparam logic [4:0] OP_FY_B = 5'd16;
   localparam logic [4:0] OP_FZ_A = 5'd17;
   localparam logic [4:0] OP_FZ_B = 5'd18;

   localparam logic [CNT_W-1:0] LEN_DIFF  = CNT_W'(DIFF_W - 1);
   localparam logic [CNT_W-1:0] LEN_NORM  = CNT_W'(NORM_W - 1);
   localparam logic [CNT_W-1:0] LEN_DOT   = CNT_W'(DOT_W - 1);
   localparam logic [CNT_W-1:0] LEN_COORD = CNT_W'(COORD_WIDTH - 1);

   function automatic wide_type sx_diff(input diff_type v);
      return {{(WIDE_W-DIFF_W){v[DIFF_W-1]}}, v};
   endfunction

   function automatic wide_type sx_coord(input coord_type v);
      return {{(WIDE_W-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
   endfunction

   function automatic diff_type sub_coord(input coord_type a, input coord_type b);
      return {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
   endfunction

   function automatic coord_type sat_foot(input logic neg,
                                          input logic [COORD_WIDTH-1:0] q);
      coord_type r;
      if (neg) begin
         if (q[COORD_WIDTH-1] && (q[COORD_WIDTH-2:0] != '0)) begin
            r = {1'b1, {(COORD_WIDTH-1){1'b0}}};
         end else begin
            r = -q;
         end
      end else if (q[COORD_WIDTH-1]) begin
         r = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end else begin
         r = q;
      end
      return r;
   endfunction

   logic [3:0]             state_ff, state_in;
   logic [4:0]             op_ff, op_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   neg_ff, neg_in;
   wide_type               acc_ff, acc_in;
   wide_type               mcand_ff, mcand_in;
   wide_type               mplier_ff, mplier_in;
   wide_type               tmp_ff, tmp_in;
   coord_type              px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   diff_type               ux_ff, ux_in, uy_ff, uy_in, uz_ff, uz_in;
   diff_type               vx_ff, vx_in, vy_ff, vy_in, vz_ff, vz_in;
   diff_type               rx_ff, rx_in, ry_ff, ry_in, rz_ff, rz_in;
   wide_type               nx_ff, nx_in, ny_ff, ny_in, nz_ff, nz_in;
   wide_type               d_ff, d_in, nn_ff, nn_in;
   logic [COORD_WIDTH-1:0] root_ff, root_in, quo_ff, quo_in;
   logic                   sign_ff, sign_in;
   logic                   degen_ff, degen_in;
   coord_type              hx_ff, hx_in, hy_ff, hy_in, hz_ff, hz_in;

   logic [4:0]             setup_op;
   logic                   s_clr, s_neg, do_setup;
   logic [CNT_W-1:0]       s_len;
   wide_type               s_mcand, s_mplier, mac_fin;
   logic                   div_ok;
   logic [COORD_WIDTH-1:0] quo_next;
   coord_type              foot_new;

   assign mac_fin  = mplier_ff[0] ? alu_sum : acc_ff;
   assign div_ok   = !alu_sum[WIDE_W-1];
   assign quo_next = {quo_ff[COORD_WIDTH-2:0], div_ok};
   assign foot_new = sat_foot(sign_ff, quo_next);

   // operand selection for the next multiply
   always_comb begin
      setup_op = (state_ff == S_SETUP) ? op_ff : op_ff + 5'd1;
      s_clr    = 1'b0;
      s_neg    = 1'b0;
      s_len    = LEN_DIFF;
      s_mcand  = '0;
      s_mplier = '0;
      case (setup_op)
         OP_NX_A: begin
            s_clr = 1'b1; s_mcand = sx_diff(uy_ff); s_mplier = sx_diff(vz_ff);
         end
         OP_NX_B: begin
            s_neg = 1'b1; s_mcand = sx_diff(uz_ff); s_mplier = sx_diff(vy_ff);
         end
         OP_NY_A: begin
            s_clr = 1'b1; s_mcand = sx_diff(uz_ff); s_mplier = sx_diff(vx_ff);
         end
         OP_NY_B: begin
            s_neg = 1'b1; s_mcand = sx_diff(ux_ff); s_mplier = sx_diff(vz_ff);
         end
         OP_NZ_A: begin
            s_clr = 1'b1; s_mcand = sx_diff(ux_ff); s_mplier = sx_diff(vy_ff);
         end
         OP_NZ_B: begin
            s_neg = 1'b1; s_mcand = sx_diff(uy_ff); s_mplier = sx_diff(vx_ff);
         end
         OP_D_A: begin
            s_clr = 1'b1; s_mcand = nx_ff; s_mplier = sx_diff(rx_ff);
         end
         OP_D_B: begin
            s_mcand = ny_ff; s_mplier = sx_diff(ry_ff);
         end
         OP_D_C: begin
            s_mcand = nz_ff; s_mplier = sx_diff(rz_ff);
         end
         OP_NN_A: begin
            s_clr = 1'b1; s_mcand = nx_ff; s_mplier = nx_ff; s_len = LEN_NORM;
         end
         OP_NN_B: begin
            s_mcand = ny_ff; s_mplier = ny_ff; s_len = LEN_NORM;
         end
         OP_NN_C: begin
            s_mcand = nz_ff; s_mplier = nz_ff; s_len = LEN_NORM;
         end
         OP_DSQ: begin
            s_clr = 1'b1; s_mcand = d_ff; s_mplier = d_ff; s_len = LEN_DOT;
         end
         OP_FX_A: begin
            s_clr = 1'b1; s_mcand = nn_ff; s_mplier = sx_coord(px_ff); s_len = LEN_COORD;
         end
         OP_FY_A: begin
            s_clr = 1'b1; s_mcand = nn_ff; s_mplier = sx_coord(py_ff); s_len = LEN_COORD;
         end
         OP_FZ_A: begin
            s_clr = 1'b1; s_mcand = nn_ff; s_mplier = sx_coord(pz_ff); s_len = LEN_COORD;
         end
         OP_FX_B: begin
            s_neg = 1'b1; s_mcand = d_ff; s_mplier = nx_ff; s_len = LEN_NORM;
         end
         OP_FY_B: begin
            s_neg = 1'b1; s_mcand = d_ff; s_mplier = ny_ff; s_len = LEN_NORM;
         end
         OP_FZ_B: begin
            s_neg = 1'b1; s_mcand = d_ff; s_mplier = nz_ff; s_len = LEN_NORM;
         end
         default: begin
            s_clr = 1'b1;
         end
      endcase
   end

   always_comb begin
      alu_req.x   = acc_ff;
      alu_req.y   = mcand_ff;
      alu_req.sub = 1'b0;
      case (state_ff)
         S_MAC: begin
            alu_req.sub = neg_ff ^ (cnt_ff == '0);
         end
         S_ABS: begin
            alu_req.x = '0; alu_req.y = acc_ff; alu_req.sub = 1'b1;
         end
         S_LIM: begin
            alu_req.x = {acc_ff[WIDE_W-2:0], 1'b0}; alu_req.y = nn_ff;
         end
         S_DIV: begin
            alu_req.sub = 1'b1;
         end
         S_SQRT_T: begin
            alu_req.x = mcand_ff; alu_req.y = mplier_ff;
         end
         S_SQRT_S: begin
            alu_req.y = tmp_ff; alu_req.sub = 1'b1;
         end
         S_SQRT_A: begin
            alu_req.x = mcand_ff; alu_req.y = {mplier_ff[WIDE_W-2:0], 1'b0};
         end
         default: begin
            alu_req.sub = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;  op_in     = op_ff;     cnt_in    = cnt_ff;
      neg_in    = neg_ff;    acc_in    = acc_ff;    mcand_in  = mcand_ff;
      mplier_in = mplier_ff; tmp_in    = tmp_ff;
      px_in = px_ff; py_in = py_ff; pz_in = pz_ff;
      ux_in = ux_ff; uy_in = uy_ff; uz_in = uz_ff;
      vx_in = vx_ff; vy_in = vy_ff; vz_in = vz_ff;
      rx_in = rx_ff; ry_in = ry_ff; rz_in = rz_ff;
      nx_in = nx_ff; ny_in = ny_ff; nz_in = nz_ff; d_in = d_ff; nn_in = nn_ff;
      root_in = root_ff; quo_in = quo_ff; sign_in = sign_ff; degen_in = degen_ff;
      hx_in = hx_ff; hy_in = hy_ff; hz_in = hz_ff;
      do_setup = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               px_in = coords.point_x;
               py_in = coords.point_y;
               pz_in = coords.point_z;
               ux_in = sub_coord(coords.second_x, coords.first_x);
               uy_in = sub_coord(coords.second_y, coords.first_y);
               uz_in = sub_coord(coords.second_z, coords.first_z);
               vx_in = sub_coord(coords.third_x, coords.first_x);
               vy_in = sub_coord(coords.third_y, coords.first_y);
               vz_in = sub_coord(coords.third_z, coords.first_z);
               rx_in = sub_coord(coords.point_x, coords.first_x);
               ry_in = sub_coord(coords.point_y, coords.first_y);
               rz_in = sub_coord(coords.point_z, coords.first_z);
               op_in    = OP_NX_A;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            do_setup = 1'b1;
         end
         S_MAC: begin
            acc_in    = mac_fin;
            mcand_in  = {mcand_ff[WIDE_W-2:0], 1'b0};
            mplier_in = {mplier_ff[WIDE_W-1], mplier_ff[WIDE_W-1:1]};
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               case (op_ff)
                  OP_NX_B: begin
                     nx_in = mac_fin; do_setup = 1'b1;
                  end
                  OP_NY_B: begin
                     ny_in = mac_fin; do_setup = 1'b1;
                  end
                  OP_NZ_B: begin
                     nz_in = mac_fin; do_setup = 1'b1;
                  end
                  OP_D_C: begin
                     d_in = mac_fin; do_setup = 1'b1;
                  end
                  OP_NN_C: begin
                     nn_in = mac_fin;
                     if (mac_fin == '0) begin
                        degen_in = 1'b1;
                        state_in = S_DONE;
                     end else begin
                        degen_in = 1'b0;
                        do_setup = 1'b1;
                     end
                  end
                  OP_DSQ: begin
                     mcand_in  = '0;
                     mplier_in = nn_ff << (2 * (COORD_WIDTH - 1));
                     cnt_in    = LEN_COORD;
                     state_in  = S_SQRT_T;
                  end
                  OP_FX_B, OP_FY_B, OP_FZ_B: begin
                     state_in = S_ABS;
                  end
                  default: begin
                     do_setup = 1'b1;
                  end
               endcase
            end
         end
         S_SQRT_T: begin
            tmp_in   = alu_sum;
            state_in = S_SQRT_S;
         end
         S_SQRT_S: begin
            if (!alu_sum[WIDE_W-1]) begin
               acc_in   = alu_sum;
               state_in = S_SQRT_A;
            end else begin
               root_in   = {root_ff[COORD_WIDTH-2:0], 1'b0};
               mcand_in  = mcand_ff >> 1;
               mplier_in = mplier_ff >> 2;
               cnt_in    = cnt_ff - 1'b1;
               state_in  = S_SQRT_T;
               if (cnt_ff == '0) begin
                  do_setup = 1'b1;
               end
            end
         end
         S_SQRT_A: begin
            root_in   = {root_ff[COORD_WIDTH-2:0], 1'b1};
            mcand_in  = alu_sum >> 1;
            mplier_in = mplier_ff >> 2;
            cnt_in    = cnt_ff - 1'b1;
            state_in  = S_SQRT_T;
            if (cnt_ff == '0) begin
               do_setup = 1'b1;
            end
         end
         S_ABS: begin
            sign_in = acc_ff[WIDE_W-1];
            if (acc_ff[WIDE_W-1]) begin
               acc_in = alu_sum;
            end
            state_in = S_LIM;
         end
         S_LIM: begin
            acc_in   = alu_sum;
            mcand_in = nn_ff << COORD_WIDTH;
            cnt_in   = LEN_COORD;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_ok) begin
               acc_in = alu_sum;
            end
            quo_in   = quo_next;
            mcand_in = mcand_ff >> 1;
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               case (op_ff)
                  OP_FX_B: hx_in = foot_new;
                  OP_FY_B: hy_in = foot_new;
                  default: hz_in = foot_new;
               endcase
               if (op_ff == OP_FZ_B) begin
                  state_in = S_DONE;
               end else begin
                  do_setup = 1'b1;
               end
            end
         end
         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (do_setup) begin
         op_in     = setup_op;
         acc_in    = s_clr ? '0 : mac_fin;
         mcand_in  = s_mcand;
         mplier_in = s_mplier;
         cnt_in    = s_len;
         neg_in    = s_neg;
         state_in  = S_MAC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         hx_ff    <= '0;
         hy_ff    <= '0;
         hz_ff    <= '0;
      end else begin
         state_ff <= state_in;
         hx_ff    <= hx_in;
         hy_ff    <= hy_in;
         hz_ff    <= hz_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;   cnt_ff <= cnt_in;     neg_ff <= neg_in;
      acc_ff <= acc_in; mcand_ff <= mcand_in; mplier_ff <= mplier_in;
      tmp_ff <= tmp_in;
      px_ff <= px_in; py_ff <= py_in; pz_ff <= pz_in;
      ux_ff <= ux_in; uy_ff <= uy_in; uz_ff <= uz_in;
      vx_ff <= vx_in; vy_ff <= vy_in; vz_ff <= vz_in;
      rx_ff <= rx_in; ry_ff <= ry_in; rz_ff <= rz_in;
      nx_ff <= nx_in; ny_ff <= ny_in; nz_ff <= nz_in;
      d_ff <= d_in;   nn_ff <= nn_in;
      root_ff <= root_in; quo_ff <= quo_in;
      sign_ff <= sign_in; degen_ff <= degen_in;
   end

   assign ready             = (state_ff == S_IDLE);
   assign done              = (state_ff == S_DONE);
   assign result.distance   = degen_ff ? '0 : root_ff;
   assign result.foot_x     = hx_ff;
   assign result.foot_y     = hy_ff;
   assign result.foot_z     = hz_ff;
   assign result.degenerate = degen_ff;

endmodule

// ===== src/point_plane_distance_foot.sv =====
// ----------------------------------------------------------------------------
// point_plane_distance_foot: distance from a point to a plane through three
// points, and the foot of the perpendicular
// One word in gives one word out. All arithmetic is exact on a single
// shared 160-bit adder/subtractor; results sit in an output register.
// ----------------------------------------------------------------------------
// From acceptance until its result has moved into the output register,
// req_ready stays low. All steps run on the one shared adder: shift-add
// multiplies at one multiplier bit per cycle for the normal, dot product,
// norm, d squared and the three foot numerators, a square root with a
// trial, a subtract and, for a one bit, an add step per result bit, and
// three restoring divides at one quotient bit per cycle.
// A new word is taken while the previous result still waits in the output
// register. Collinear plane points flag degenerate, give distance 0 and
// repeat the last stored foot.
module point_plane_distance_foot import ppdf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  coord_type              req_point_x,
   input  coord_type              req_point_y,
   input  coord_type              req_point_z,
   input  coord_type              req_first_x,
   input  coord_type              req_first_y,
   input  coord_type              req_first_z,
   input  coord_type              req_second_x,
   input  coord_type              req_second_y,
   input  coord_type              req_second_z,
   input  coord_type              req_third_x,
   input  coord_type              req_third_y,
   input  coord_type              req_third_z,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [COORD_WIDTH-1:0] rsp_distance,
   output coord_type              rsp_foot_x,
   output coord_type              rsp_foot_y,
   output coord_type              rsp_foot_z,
   output logic                   rsp_degenerate
);

   coords_type     coords;
   addsub_req_type alu_req;
   wide_type       alu_sum;
   result_type     eng_result;
   result_type     rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           eng_ready, eng_done, eng_take, start;

   assign coords = '{req_point_x, req_point_y, req_point_z,
                     req_first_x, req_first_y, req_first_z,
                     req_second_x, req_second_y, req_second_z,
                     req_third_x, req_third_y, req_third_z};

   assign start    = req_valid && eng_ready;
   assign eng_take = eng_done && (!rsp_valid_ff || rsp_ready);

   ppdf_addsub u_addsub (
      .req (alu_req),
      .sum (alu_sum)
   );

   ppdf_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .coords  (coords),
      .take    (eng_take),
      .ready   (eng_ready),
      .done    (eng_done),
      .result  (eng_result),
      .alu_req (alu_req),
      .alu_sum (alu_sum)
   );

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (eng_take) begin
         rsp_in       = eng_result;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign req_ready      = eng_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_distance   = rsp_ff.distance;
   assign rsp_foot_x     = rsp_ff.foot_x;
   assign rsp_foot_y     = rsp_ff.foot_y;
   assign rsp_foot_z     = rsp_ff.foot_z;
   assign rsp_degenerate = rsp_ff.degenerate;

   a_degen_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_distance == '0)
      else $error("degenerate word with nonzero distance");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready after accepting a word");

   a_load: assert property (@(posedge clock) disable iff (reset)
      eng_take |=> rsp_valid && !eng_done)
      else $error("finished result not moved to output register");

endmodule

// ===== sim/tb_point_plane_distance_foot.sv =====
// ----------------------------------------------------------------------------
// tb_point_plane_distance_foot: self-checking bench for the plane distance
// Sends directed corner planes, then random planes and points, with random
// idle bursts on both channels and one long output stall. A scoreboard
// predicts distance, foot and degenerate flag exactly and checks each word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_point_plane_distance_foot;
   import ppdf_pkg::*;

   localparam int    N_RANDOM   = 380;
   localparam int    QUIET_FROM = 340;
   localparam int    STALL_AT   = 40;
   localparam int    STALL_LEN  = 4000;
   localparam longint LIMIT     = 3000000;
   localparam coord_type C_MAX  = coord_type'(24'h7fffff);
   localparam coord_type C_MIN  = coord_type'(24'h800000);

   typedef logic signed [255:0] acc_type;

   class plane_scoreboard;
      result_type expected_q[$];
      coord_type  held_x, held_y, held_z;
      int         accepted, checked, degenerates, errors;

      function new();
         held_x = '0; held_y = '0; held_z = '0;
         accepted = 0; checked = 0; degenerates = 0; errors = 0;
      endfunction

      function coord_type foot_axis(coord_type p, acc_type d, acc_type n, acc_type nn);
         acc_type num, m, q;
         logic    neg;
         num = acc_type'(p) * nn - d * n;
         neg = num < 0;
         m   = neg ? -num : num;
         q   = (2 * m + nn) / (2 * nn);
         if (q > acc_type'(24'hffffff)) q = acc_type'(24'hffffff);
         if (neg) begin
            if (q > acc_type'(24'h800000)) q = acc_type'(24'h800000);
            return coord_type'(-q);
         end
         if (q > acc_type'(24'h7fffff)) q = acc_type'(24'h7fffff);
         return coord_type'(q);
      endfunction

      function void note_word(coords_type c);
         acc_type    ux, uy, uz, vx, vy, vz, rx, ry, rz, nx, ny, nz, d, nn, dd, t, x;
         result_type r;
         ux = acc_type'(c.second_x) - acc_type'(c.first_x);
         uy = acc_type'(c.second_y) - acc_type'(c.first_y);
         uz = acc_type'(c.second_z) - acc_type'(c.first_z);
         vx = acc_type'(c.third_x) - acc_type'(c.first_x);
         vy = acc_type'(c.third_y) - acc_type'(c.first_y);
         vz = acc_type'(c.third_z) - acc_type'(c.first_z);
         rx = acc_type'(c.point_x) - acc_type'(c.first_x);
         ry = acc_type'(c.point_y) - acc_type'(c.first_y);
         rz = acc_type'(c.point_z) - acc_type'(c.first_z);
         nx = uy * vz - uz * vy;
         ny = uz * vx - ux * vz;
         nz = ux * vy - uy * vx;
         d  = nx * rx + ny * ry + nz * rz;
         nn = nx * nx + ny * ny + nz * nz;
         accepted++;
         if (nn == 0) begin
            r.distance   = '0;
            r.degenerate = 1'b1;
            degenerates++;
         end else begin
            dd = d * d;
            x  = 0;
            for (int b = COORD_WIDTH - 1; b >= 0; b--) begin
               t = x | (acc_type'(1) << b);
               if (t * t * nn <= dd) x = t;
            end
            r.distance   = x[COORD_WIDTH-1:0];
            held_x       = foot_axis(c.point_x, d, nx, nn);
            held_y       = foot_axis(c.point_y, d, ny, nn);
            held_z       = foot_axis(c.point_z, d, nz, nn);
            r.degenerate = 1'b0;
         end
         r.foot_x = held_x;
         r.foot_y = held_y;
         r.foot_z = held_z;
         expected_q.push_back(r);
      endfunction

      function void check_word(result_type a);
         result_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, a);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         checked++;
         if (a.distance !== e.distance) begin
            $display("%0t: distance exp %0d got %0d", $time, e.distance, a.distance);
            errors++;
         end
         if (a.foot_x !== e.foot_x) begin
            $display("%0t: foot_x exp %0d got %0d", $time, e.foot_x, a.foot_x);
            errors++;
         end
         if (a.foot_y !== e.foot_y) begin
            $display("%0t: foot_y exp %0d got %0d", $time, e.foot_y, a.foot_y);
            errors++;
         end
         if (a.foot_z !== e.foot_z) begin
            $display("%0t: foot_z exp %0d got %0d", $time, e.foot_z, a.foot_z);
            errors++;
         end
         if (a.degenerate !== e.degenerate) begin
            $display("%0t: degenerate exp %0b got %0b", $time, e.degenerate, a.degenerate);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   coords_type req_word = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   result_type rsp_word;
   longint     cycles = 0;
   logic       quiet = 1'b0;
   plane_scoreboard sb = new();

   always #6 clock = ~clock;

   point_plane_distance_foot u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_point_x    (req_word.point_x),
      .req_point_y    (req_word.point_y),
      .req_point_z    (req_word.point_z),
      .req_first_x    (req_word.first_x),
      .req_first_y    (req_word.first_y),
      .req_first_z    (req_word.first_z),
      .req_second_x   (req_word.second_x),
      .req_second_y   (req_word.second_y),
      .req_second_z   (req_word.second_z),
      .req_third_x    (req_word.third_x),
      .req_third_y    (req_word.third_y),
      .req_third_z    (req_word.third_z),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_distance   (rsp_word.distance),
      .rsp_foot_x     (rsp_word.foot_x),
      .rsp_foot_y     (rsp_word.foot_y),
      .rsp_foot_z     (rsp_word.foot_z),
      .rsp_degenerate (rsp_word.degenerate)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("%0t: timeout", $time);
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready) sb.check_word(rsp_word);

   // receiver: random ready bursts, one long hold-off, none at the end
   initial begin
      int  len;
      bit  stalled;
      stalled = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!stalled && sb.accepted >= STALL_AT) begin
            stalled = 1;
            rsp_ready <= 1'b0;
            repeat (STALL_LEN) @(posedge clock);
         end else if (quiet) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else begin
            len = $urandom_range(1, 10);
            rsp_ready <= ($urandom_range(0, 2) != 0);
            repeat (len) @(posedge clock);
         end
      end
   end

   function automatic coord_type pick_coord(int mode);
      case (mode)
         0: return coord_type'($urandom);
         1: return coord_type'($urandom_range(0, 4095)) - coord_type'(2048);
         default: begin
            case ($urandom_range(0, 4))
               0: return C_MAX;
               1: return C_MIN;
               2: return '0;
               3: return coord_type'(-1);
               default: return coord_type'($urandom);
            endcase
         end
      endcase
   endfunction

   task automatic send_word(coords_type c);
      int gap;
      gap = (quiet || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_word  <= c;
      req_valid <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      sb.note_word(c);
   endtask

   task automatic send_plane(coord_type p[3], coord_type a[3], coord_type b[3],
                             coord_type e[3]);
      coords_type c;
      c = '{p[0], p[1], p[2], a[0], a[1], a[2], b[0], b[1], b[2], e[0], e[1], e[2]};
      send_word(c);
   endtask

   initial begin
      coords_type c;
      coord_type  k;
      int         mode, shape;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // degenerate before any foot is held: foot must read zero
      send_plane('{256, 256, 256}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0});
      send_plane('{0, 0, 1280}, '{0, 0, 0}, '{256, 0, 0}, '{0, 256, 0});
      send_plane('{-768, 512, -1280}, '{0, 0, 0}, '{256, 0, 0}, '{0, 256, 0});
      // collinear points repeat the held foot
      send_plane('{9, 9, 9}, '{0, 0, 0}, '{256, 256, 256}, '{512, 512, 512});
      send_plane('{C_MAX, C_MAX, C_MAX}, '{C_MIN, C_MIN, C_MIN}, '{0, 0, 0},
                 '{C_MAX, C_MAX, C_MAX});
      send_plane('{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0});
      // distance saturates
      send_plane('{C_MAX, C_MAX, C_MAX}, '{C_MIN + 1, C_MIN + 1, C_MIN + 1},
                 '{C_MIN + 2, C_MIN, C_MIN + 1}, '{C_MIN + 2, C_MIN + 1, C_MIN});
      send_plane('{C_MIN, C_MIN, C_MIN}, '{C_MAX - 1, C_MAX - 1, C_MAX - 1},
                 '{C_MAX - 2, C_MAX, C_MAX - 1}, '{C_MAX - 2, C_MAX - 1, C_MAX});
      // tilted planes near a corner push the foot out of range
      send_plane('{C_MIN, C_MIN, C_MIN}, '{C_MAX, C_MAX, C_MIN},
                 '{C_MAX, C_MIN, C_MAX}, '{C_MIN, C_MAX, C_MAX});
      send_plane('{C_MAX, C_MAX, C_MAX}, '{C_MIN, C_MIN, C_MAX},
                 '{C_MIN, C_MAX, C_MIN}, '{C_MAX, C_MIN, C_MIN});
      send_plane('{C_MAX, C_MIN, 0}, '{0, 0, 0}, '{0, 0, 256}, '{256, 256, 0});
      send_plane('{C_MIN, C_MAX, C_MIN}, '{C_MAX, C_MIN, C_MAX},
                 '{C_MIN, C_MIN, C_MIN}, '{C_MAX, C_MAX, C_MIN});
      send_plane('{-1, -1, -1}, '{1, 0, 0}, '{0, 1, 0}, '{0, 0, 1});
      send_plane('{1, 2, 3}, '{C_MAX, 0, 0}, '{0, C_MAX, 0}, '{0, 0, C_MAX});
      send_plane('{C_MAX, C_MAX, C_MAX}, '{C_MIN, C_MIN, C_MIN}, '{C_MAX, C_MIN, C_MIN},
                 '{C_MIN, C_MAX, C_MIN});

      for (int i = 0; i < N_RANDOM; i++) begin
         if (sb.accepted >= QUIET_FROM) quiet <= 1'b1;
         mode  = $urandom_range(0, 2);
         shape = $urandom_range(0, 9);
         c.point_x  = pick_coord(mode); c.point_y  = pick_coord(mode);
         c.point_z  = pick_coord(mode);
         c.first_x  = pick_coord(mode); c.first_y  = pick_coord(mode);
         c.first_z  = pick_coord(mode);
         c.second_x = pick_coord(mode); c.second_y = pick_coord(mode);
         c.second_z = pick_coord(mode);
         c.third_x  = pick_coord(mode); c.third_y  = pick_coord(mode);
         c.third_z  = pick_coord(mode);
         if (shape == 0) begin
            // third point on the line through the first two
            k = coord_type'($urandom_range(0, 4)) - coord_type'(2);
            c.first_x  = pick_coord(1); c.first_y = pick_coord(1);
            c.first_z  = pick_coord(1);
            c.second_x = pick_coord(1); c.second_y = pick_coord(1);
            c.second_z = pick_coord(1);
            c.third_x  = c.first_x + k * (c.second_x - c.first_x);
            c.third_y  = c.first_y + k * (c.second_y - c.first_y);
            c.third_z  = c.first_z + k * (c.second_z - c.first_z);
         end else if (shape == 1) begin
            c.third_x = c.second_x; c.third_y = c.second_y; c.third_z = c.second_z;
         end
         send_word(c);
      end

      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Sent %0d words (%0d degenerate), checked %0d results.",
               sb.accepted, sb.degenerates, sb.checked);
      $display("Covered corner planes, saturation, collinear planes and a long output stall.");
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
